// ===== hw/rtl/u8d_pkg.sv =====
// ----------------------------------------------------------------------------
// u8d_pkg
// Types, constants and helpers shared by the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int CP_W   = 21;
    localparam int BYTE_W = 8;
    localparam int PEND_W = 2;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Depth of the result queue in front of the output port.
    localparam int QDEPTH = 3;
    localparam int QIDX_W = 2;
    localparam int QCNT_W = 2;

    // Register indexes, taken from paddr[2].
    localparam logic REG_SKIP_ZW = 1'b0;
    localparam logic REG_REPL    = 1'b1;

    localparam logic            SKIP_RESET = 1'b1;
    localparam logic [CP_W-1:0] REPL_RESET = 21'd63;

    localparam logic [CP_W-1:0] ZW_SPACE_LO = 21'h0200B;
    localparam logic [CP_W-1:0] ZW_SPACE_HI = 21'h0200F;
    localparam logic [CP_W-1:0] VAR_SEL_LO  = 21'h0FE00;
    localparam logic [CP_W-1:0] VAR_SEL_HI  = 21'h0FE0F;
    localparam logic [CP_W-1:0] BOM_CP      = 21'h0FEFF;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              string_end;
    } t_byte_word;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            point_valid;
        logic            last_of_string;
    } t_point_word;

    typedef struct packed {
        logic [PEND_W-1:0] bytes_pending;
        logic [CP_W-1:0]   partial_value;
    } t_dec_state;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        t_point_word       res0;
        t_point_word       res1;
    } t_step_res;

    function automatic logic is_zero_width(input logic [CP_W-1:0] cp);
        return ((cp >= ZW_SPACE_LO) && (cp <= ZW_SPACE_HI)) ||
               ((cp >= VAR_SEL_LO) && (cp <= VAR_SEL_HI)) ||
               (cp == BOM_CP);
    endfunction

endpackage

// ===== hw/rtl/u8d_if.sv =====
// ----------------------------------------------------------------------------
// u8d_if
// Valid/ready channels for input bytes and decoded code points.
// ----------------------------------------------------------------------------
interface u8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       string_end;

    modport source (output valid, output text_byte, output string_end, input ready);
    modport sink   (input valid, input text_byte, input string_end, output ready);
endinterface

interface u8d_point_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        point_valid;
    logic        last_of_string;

    modport source (output valid, output code_point, output point_valid,
                    output last_of_string, input ready);
    modport sink   (input valid, input code_point, input point_valid,
                    input last_of_string, output ready);
endinterface

// ===== hw/rtl/u8d_step.sv =====
// ----------------------------------------------------------------------------
// u8d_step
// Decodes one byte against the sequence state and gives up to two results.
// ----------------------------------------------------------------------------
module u8d_step (
    input  u8d_pkg::t_dec_state            i_state,
    input  u8d_pkg::t_byte_word            i_word,
    input  logic                           i_skip,
    input  logic [u8d_pkg::CP_W-1:0]       i_repl,
    output u8d_pkg::t_dec_state            o_state,
    output u8d_pkg::t_step_res             o_res
);

    logic [7:0]                   b;
    logic                         is_cont;
    logic                         open_seq;
    logic                         f_emit;
    logic [u8d_pkg::CP_W-1:0]     f_cp;
    logic [u8d_pkg::PEND_W-1:0]   f_pend;
    logic [u8d_pkg::CP_W-1:0]     f_part;
    logic [u8d_pkg::PEND_W-1:0]   cont_pend;
    logic [u8d_pkg::CP_W-1:0]     cont_val;
    logic                         c1_en;
    logic [u8d_pkg::CP_W-1:0]     c1_cp;
    logic                         c2_en;
    logic [u8d_pkg::CP_W-1:0]     c2_cp;
    logic                         k1;
    logic                         k2;
    u8d_pkg::t_dec_state          mid_state;
    u8d_pkg::t_point_word         w1;
    u8d_pkg::t_point_word         w2;

    assign b        = i_word.text_byte;
    assign is_cont  = (b[7:6] == 2'b10);
    assign open_seq = (i_state.bytes_pending != '0);

    // Decode of a byte with no sequence open.
    always_comb begin
        f_emit = 1'b0;
        f_cp   = i_repl;
        f_pend = '0;
        f_part = '0;
        unique if (b[7] == 1'b0) begin
            f_emit = 1'b1;
            f_cp   = {{(u8d_pkg::CP_W-8){1'b0}}, b};
        end else if (b[7:5] == 3'b110) begin
            f_pend = 2'd1;
            f_part = {{(u8d_pkg::CP_W-5){1'b0}}, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            f_pend = 2'd2;
            f_part = {{(u8d_pkg::CP_W-4){1'b0}}, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            f_pend = 2'd3;
            f_part = {{(u8d_pkg::CP_W-3){1'b0}}, b[2:0]};
        end else begin
            f_emit = 1'b1;
        end
    end

    assign cont_pend = i_state.bytes_pending - 2'd1;
    assign cont_val  = {i_state.partial_value[u8d_pkg::CP_W-7:0], b[5:0]};

    // First candidate: a completed sequence or the replacement for an
    // interrupted one. Second candidate: a fresh point or the replacement for
    // a sequence cut off by the end of the string. Both can be given for one byte.
    always_comb begin
        c1_en = 1'b0;
        c1_cp = i_repl;
        c2_en = 1'b0;
        c2_cp = i_repl;
        if (open_seq && is_cont) begin
            mid_state.bytes_pending = cont_pend;
            mid_state.partial_value = (cont_pend == '0) ? '0 : cont_val;
            c1_en = (cont_pend == '0);
            c1_cp = cont_val;
        end else begin
            mid_state.bytes_pending = f_pend;
            mid_state.partial_value = f_part;
            c1_en = open_seq;
            c2_en = f_emit;
            c2_cp = f_cp;
        end
        o_state = mid_state;
        if (i_word.string_end) begin
            o_state = '0;
            if (mid_state.bytes_pending != '0) begin
                c2_en = 1'b1;
                c2_cp = i_repl;
            end
        end
    end

    assign k1 = c1_en && !(i_skip && u8d_pkg::is_zero_width(c1_cp));
    assign k2 = c2_en && !(i_skip && u8d_pkg::is_zero_width(c2_cp));

    always_comb begin
        w1 = '{code_point: c1_cp, point_valid: 1'b1, last_of_string: 1'b0};
        w2 = '{code_point: c2_cp, point_valid: 1'b1, last_of_string: 1'b0};
        o_res.res0  = k1 ? w1 : w2;
        o_res.res1  = w2;
        o_res.count = {1'b0, k1} + {1'b0, k2};
        if (i_word.string_end) begin
            unique case ({k1, k2})
                2'b00: begin
                    o_res.res0  = '{code_point: '0, point_valid: 1'b0,
                                    last_of_string: 1'b1};
                    o_res.count = 2'd1;
                end
                2'b01, 2'b10: begin
                    o_res.res0.last_of_string = 1'b1;
                end
                2'b11: begin
                    o_res.res1.last_of_string = 1'b1;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/utf8_codepoint_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder
// Streaming UTF-8 decoder: one byte in, zero to two code point words out.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                                    Word accepted when
// i_in      in   text_byte[7:0], string_end                 valid && ready
// o_out     out  code_point[20:0], point_valid, last_of...  valid && ready
// apb       in   paddr[2:0], pwdata[31:0] / prdata[31:0]    psel && penable && pwrite
//
// A byte is registered on acceptance and decoded, once the queue holds at most
// one word, into a three-word result queue; o_out shows the queue head straight
// from a register. Throughput is one byte per cycle while o_out.ready is high;
// a two-word byte can stall i_in; bytes are taken at one queued word or less.
// Reset (synchronous, active low) closes any open sequence, empties the queue
// and restores skip_zero_width = 1 and replacement_code = 63.
// i_in.ready depends on registers only, never on o_out.ready.
module utf8_codepoint_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    u8d_byte_if.sink                      i_in,
    u8d_point_if.source                   o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [u8d_pkg::ADDR_W-1:0]    paddr,
    input  logic [u8d_pkg::DATA_W-1:0]    pwdata,
    output logic [u8d_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    logic                          r_skip;
    logic [u8d_pkg::CP_W-1:0]      r_repl;
    logic                          r_in_valid;
    u8d_pkg::t_byte_word           r_in;
    u8d_pkg::t_dec_state           r_state;
    u8d_pkg::t_dec_state           n_state;
    u8d_pkg::t_step_res            step_res;
    u8d_pkg::t_point_word          r_q [u8d_pkg::QDEPTH];
    u8d_pkg::t_point_word          n_q [u8d_pkg::QDEPTH];
    logic [u8d_pkg::QCNT_W-1:0]    r_cnt;
    logic [u8d_pkg::QCNT_W-1:0]    n_cnt;
    logic [u8d_pkg::QCNT_W-1:0]    push_cnt;
    logic [u8d_pkg::QIDX_W-1:0]    base;
    logic                          advance;
    logic                          step;
    logic                          pop;
    logic                          in_take;
    logic                          cfg_wr;

    // ---- configuration ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= u8d_pkg::SKIP_RESET;
            r_repl <= u8d_pkg::REPL_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                u8d_pkg::REG_SKIP_ZW: r_skip <= pwdata[0];
                u8d_pkg::REG_REPL:    r_repl <= pwdata[u8d_pkg::CP_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            u8d_pkg::REG_SKIP_ZW: prdata = {{(u8d_pkg::DATA_W-1){1'b0}}, r_skip};
            u8d_pkg::REG_REPL:
                prdata = {{(u8d_pkg::DATA_W-u8d_pkg::CP_W){1'b0}}, r_repl};
        endcase
    end

    // ---- input register ----
    assign advance    = (r_cnt <= 2'd1);
    assign step       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.text_byte  <= i_in.text_byte;
            r_in.string_end <= i_in.string_end;
        end
    end

    // ---- decode ----
    u8d_step u_step (
        .i_state (r_state),
        .i_word  (r_in),
        .i_skip  (r_skip),
        .i_repl  (r_repl),
        .o_state (n_state),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (step) begin
            r_state <= n_state;
        end
    end

    // ---- result queue, head at entry 0 ----
    assign pop      = (r_cnt != '0) && o_out.ready;
    assign push_cnt = step ? step_res.count : '0;
    assign base     = r_cnt - {1'b0, pop};

    always_comb begin
        for (int i = 0; i < u8d_pkg::QDEPTH; i++) begin
            n_q[i] = r_q[i];
        end
        if (pop) begin
            for (int i = 0; i < u8d_pkg::QDEPTH - 1; i++) begin
                n_q[i] = r_q[i+1];
            end
        end
        if (push_cnt != '0) begin
            n_q[base] = step_res.res0;
        end
        if (push_cnt == 2'd2) begin
            n_q[base + 2'd1] = step_res.res1;
        end
        n_cnt = base + push_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < u8d_pkg::QDEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    assign o_out.valid          = (r_cnt != '0);
    assign o_out.code_point     = r_q[0].code_point;
    assign o_out.point_valid    = r_q[0].point_valid;
    assign o_out.last_of_string = r_q[0].last_of_string;

endmodule

// ===== hw/rtl/u8d_check.sv =====
// ----------------------------------------------------------------------------
// u8d_check
// Port-level checks for the UTF-8 decoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8d_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [20:0] i_code_point,
    input logic        i_point_valid,
    input logic        i_last_of_string
);

    // A word shown on the output stays until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_code_point) && $stable(i_point_valid) && $stable(i_last_of_string))
        else $error("output word changed while stalled");

    // The decoder only refuses bytes while decoded words wait downstream.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with an empty result queue");

    // An end-only marker is always the last word of its string and carries zero.
    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_point_valid |-> i_last_of_string && (i_code_point == 21'd0))
        else $error("malformed end-of-string marker");

endmodule

bind utf8_codepoint_decoder u8d_check u_check (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_code_point     (o_out.code_point),
    .i_point_valid    (o_out.point_valid),
    .i_last_of_string (o_out.last_of_string)
);

// ===== verif/tb_utf8_codepoint_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_codepoint_decoder
// Feeds byte strings into the UTF-8 decoder: a short directed opening, then
// mostly well-formed random sequences mixed with truncated ones and stray
// bytes. It runs under four idling patterns and several register settings.
// A scoreboard predicts every code point word and checks each output word
// in order.
// ----------------------------------------------------------------------------
module tb_utf8_codepoint_decoder;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned PHASE_BYTES = 108;

    // Tracks the decoder's open sequence and configuration. It holds the code
    // point words still owed by the block.
    class decode_tracker;
        logic                     skip_zw;
        logic [u8d_pkg::CP_W-1:0] repl_cp;
        logic [1:0]               open_count;
        logic [u8d_pkg::CP_W-1:0] gathered;
        u8d_pkg::t_point_word     points_due[$];
        u8d_pkg::t_point_word     step_points[$];
        int unsigned              errors;

        function new();
            skip_zw    = u8d_pkg::SKIP_RESET;
            repl_cp    = u8d_pkg::REPL_RESET;
            open_count = '0;
            gathered   = '0;
            errors     = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] value);
            if (idx == u8d_pkg::REG_SKIP_ZW) begin
                skip_zw = value[0];
            end else begin
                repl_cp = value[u8d_pkg::CP_W-1:0];
            end
        endfunction

        function void give(logic [u8d_pkg::CP_W-1:0] cp);
            u8d_pkg::t_point_word w;
            if (skip_zw && (((cp >= u8d_pkg::ZW_SPACE_LO) && (cp <= u8d_pkg::ZW_SPACE_HI)) ||
                            ((cp >= u8d_pkg::VAR_SEL_LO) && (cp <= u8d_pkg::VAR_SEL_HI)) ||
                            (cp == u8d_pkg::BOM_CP)))
                return;
            w.code_point     = cp;
            w.point_valid    = 1'b1;
            w.last_of_string = 1'b0;
            step_points.push_back(w);
        endfunction

        function void start_fresh(logic [7:0] b);
            if (b < 8'h80) begin
                give(21'(b));
            end else if (b[7:5] == 3'b110) begin
                open_count = 2'd1;
                gathered   = 21'(b[4:0]);
            end else if (b[7:4] == 4'b1110) begin
                open_count = 2'd2;
                gathered   = 21'(b[3:0]);
            end else if (b[7:3] == 5'b11110) begin
                open_count = 2'd3;
                gathered   = 21'(b[2:0]);
            end else begin
                give(repl_cp);
            end
        endfunction

        function void push_byte(logic [7:0] b, logic last);
            u8d_pkg::t_point_word w;
            step_points.delete();
            if (open_count != 0) begin
                if (b[7:6] == 2'b10) begin
                    gathered   = {gathered[u8d_pkg::CP_W-7:0], b[5:0]};
                    open_count = open_count - 2'd1;
                    if (open_count == 0) begin
                        give(gathered);
                        gathered = '0;
                    end
                end else begin
                    // An interrupted sequence yields the replacement, then the
                    // interrupting byte is decoded on its own.
                    open_count = '0;
                    gathered   = '0;
                    give(repl_cp);
                    start_fresh(b);
                end
            end else begin
                start_fresh(b);
            end
            if (last) begin
                if (open_count != 0) begin
                    open_count = '0;
                    gathered   = '0;
                    give(repl_cp);
                end
                if (step_points.size() == 0) begin
                    w = '0;
                    w.last_of_string = 1'b1;
                    step_points.push_back(w);
                end else begin
                    w = step_points.pop_back();
                    w.last_of_string = 1'b1;
                    step_points.push_back(w);
                end
            end
            foreach (step_points[i]) points_due.push_back(step_points[i]);
        endfunction

        function void check_point(u8d_pkg::t_point_word got);
            u8d_pkg::t_point_word want;
            if (points_due.size() == 0) begin
                if (errors < 10)
                    $display("unexpected word: code_point %h point_valid %b last %b",
                             got.code_point, got.point_valid, got.last_of_string);
                errors++;
                return;
            end
            want = points_due.pop_front();
            if ((got.code_point !== want.code_point) ||
                (got.point_valid !== want.point_valid) ||
                (got.last_of_string !== want.last_of_string)) begin
                if (errors < 10)
                    $display("word mismatch: code_point %h/%h point_valid %b/%b last %b/%b",
                             want.code_point, got.code_point, want.point_valid,
                             got.point_valid, want.last_of_string, got.last_of_string);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [u8d_pkg::ADDR_W-1:0]   paddr;
    logic [u8d_pkg::DATA_W-1:0]   pwdata;
    logic [u8d_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    u8d_byte_if  byte_ch ();
    u8d_point_if point_ch ();

    decode_tracker tracker;
    int unsigned   gap_pct;
    int unsigned   stall_pct;
    int unsigned   bytes_sent;
    int unsigned   cycle_count;

    utf8_codepoint_decoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (point_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        point_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Input words are noted before output words so that a prediction always
    // exists by the time its word can appear.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (byte_ch.valid && byte_ch.ready)
                tracker.push_byte(byte_ch.text_byte, byte_ch.string_end);
            if (point_ch.valid && point_ch.ready)
                tracker.check_point({point_ch.code_point, point_ch.point_valid,
                                     point_ch.last_of_string});
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_utf8_codepoint_decoder: done, errors");
            $finish;
        end
    end

    function automatic logic [7:0] lead_byte(int unsigned len);
        case (len)
            1:       return {1'b0, 7'($urandom_range(1, 127))};
            2:       return {3'b110, 5'($urandom)};
            3:       return {4'b1110, 4'($urandom)};
            default: return {5'b11110, 3'($urandom)};
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < gap_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.text_byte  <= b;
        byte_ch.string_end <= last;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    // A byte that completes nothing leaves no word to wait for, so the task waits
    // on past the last expected word before the block counts as idle.
    task automatic settle();
        @(posedge i_clk);
        while (tracker.points_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random_run();
        logic [7:0]               seq[$];
        logic [u8d_pkg::CP_W-1:0] cp;
        int unsigned              kind;
        int unsigned              len;
        kind = $urandom_range(99);
        if (kind < 12) begin
            // Zero-width points and their neighbors, in three-byte form.
            case ($urandom_range(3))
                0:       cp = u8d_pkg::ZW_SPACE_LO + 21'($urandom_range(4));
                1:       cp = u8d_pkg::VAR_SEL_LO + 21'($urandom_range(15));
                2:       cp = u8d_pkg::BOM_CP;
                default: begin
                    case ($urandom_range(5))
                        0:       cp = u8d_pkg::ZW_SPACE_LO - 21'd1;
                        1:       cp = u8d_pkg::ZW_SPACE_HI + 21'd1;
                        2:       cp = u8d_pkg::VAR_SEL_LO - 21'd1;
                        3:       cp = u8d_pkg::VAR_SEL_HI + 21'd1;
                        4:       cp = u8d_pkg::BOM_CP - 21'd1;
                        default: cp = u8d_pkg::BOM_CP + 21'd1;
                    endcase
                end
            endcase
            seq = '{{4'b1110, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
        end else if (kind < 72) begin
            len = $urandom_range(1, 4);
            seq.push_back(lead_byte(len));
            repeat (len - 1) seq.push_back({2'b10, 6'($urandom)});
        end else if (kind < 86) begin
            // Truncated sequence; what follows cuts it off unless it is a continuation byte.
            len = $urandom_range(2, 4);
            seq.push_back(lead_byte(len));
            repeat ($urandom_range(0, len - 2)) seq.push_back({2'b10, 6'($urandom)});
        end else begin
            seq.push_back(8'($urandom_range(1, 255)));
        end
        foreach (seq[i]) send_byte(seq[i], $urandom_range(99) < 8);
    endtask

    task automatic run_phase(input int unsigned gap, input int unsigned stall,
                             input logic skip, input logic [u8d_pkg::CP_W-1:0] repl);
        int unsigned target;
        settle();
        write_reg(u8d_pkg::REG_SKIP_ZW, 32'(skip));
        write_reg(u8d_pkg::REG_REPL, 32'(repl));
        gap_pct   = gap;
        stall_pct = stall;
        target    = bytes_sent + PHASE_BYTES;
        while (bytes_sent < target) send_random_run();
        byte_ch.valid <= 1'b0;
    endtask

    initial begin
        logic [8:0] opening[$];
        tracker     = new();
        gap_pct     = 0;
        stall_pct   = 0;
        bytes_sent  = 0;
        cycle_count = 0;
        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        byte_ch.valid      = 1'b0;
        byte_ch.text_byte  = 8'h20;
        byte_ch.string_end = 1'b0;
        point_ch.ready     = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bit 8 marks the last byte of a string. Runs at the reset settings:
        // ASCII extremes, two-, three- and four-byte forms, a dropped
        // zero-width space, a stray continuation, an invalid lead, an
        // interrupted sequence, a string ending inside a sequence, a string
        // ending on a dropped point, and the largest 21-bit value.
        opening = '{9'h001, 9'h17F, 9'h0C3, 9'h0A9, 9'h0E2, 9'h082, 9'h0AC,
                    9'h0E2, 9'h080, 9'h08B, 9'h080, 9'h0FF, 9'h0C3, 9'h041,
                    9'h0E2, 9'h182, 9'h0EF, 9'h0B8, 9'h180, 9'h0F7, 9'h0BF,
                    9'h0BF, 9'h1BF};
        foreach (opening[i]) send_byte(opening[i][7:0], opening[i][8]);
        byte_ch.valid <= 1'b0;

        run_phase(0, 0, 1'b0, 21'h00FFFD);
        run_phase(57, 0, 1'b1, 21'h000000);
        run_phase(0, 57, 1'b0, 21'h10FFFF);
        run_phase(31, 31, 1'b1, u8d_pkg::BOM_CP);

        settle();
        if ((tracker.errors == 0) && (tracker.points_due.size() == 0)) begin
            $display("tb_utf8_codepoint_decoder: done, clean");
        end else begin
            $display("tb_utf8_codepoint_decoder: done, errors");
        end
        $finish;
    end

endmodule
